// ===== hw/rtl/aabb_signed_distance_normal_top_macros.svh =====
// assertion helpers used by aabb_sdn_back
`ifndef AABB_SIGNED_DISTANCE_NORMAL_TOP_MACROS_SVH
`define AABB_SIGNED_DISTANCE_NORMAL_TOP_MACROS_SVH

// plain property, checked on every edge out of reset
`define AABB_SDN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define AABB_SDN_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    `AABB_SDN_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/aabb_sdn_pkg.sv =====
// ----------------------------------------------------------------------------
// aabb_sdn_pkg
// shared constants, codes and types of the box signed distance block
// ----------------------------------------------------------------------------
`default_nettype none

package aabb_sdn_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NORM_W         = 16;
    localparam int NORM_ONE       = 16384;
    localparam int DIV_STEPS      = 15;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [2:0] {
        FACE_XLO,
        FACE_XHI,
        FACE_YLO,
        FACE_YHI,
        FACE_ZLO,
        FACE_ZHI
    } t_face;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X,
        REG_MIN_Y,
        REG_MIN_Z,
        REG_MAX_X,
        REG_MAX_Y,
        REG_MAX_Z,
        REG_FLIP
    } t_reg_idx;

    // width of one classified item between front and back
    function automatic int item_w(input int cw);
        return 4 * cw + 14;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aabb_sdn_front.sv =====
// ----------------------------------------------------------------------------
// aabb_sdn_front
// face clearances and classification (inside, one face, several faces)
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_sdn_front #(
    parameter int COORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic signed [COORD_BITS-1:0] i_point [3],
    input  logic        [COORD_BITS-2:0] i_radius,
    input  logic signed [COORD_BITS-1:0] i_box_min [3],
    input  logic signed [COORD_BITS-1:0] i_box_max [3],
    input  logic                         i_flip,
    output logic                         o_q_push,
    output logic [aabb_sdn_pkg::item_w(COORD_BITS)-1:0] o_q_data,
    input  logic                         i_q_full
);
    import aabb_sdn_pkg::*;

    localparam int AW = COORD_BITS + 1;
    localparam int XW = COORD_BITS + 2;

    typedef struct packed {
        logic                  flip;
        logic                  multi;
        logic                  in_box;
        t_face                 face;
        logic signed [XW-1:0]  csel;
        logic [2:0]            neg;
        logic [2:0][AW-1:0]    ax;
    } t_item;

    logic                 fe;
    logic                 r_v1, r_v2;
    logic signed [XW-1:0] r_c [6];
    logic signed [XW-1:0] n_c [6];
    t_item                r_item, n_item;

    logic [5:0]           viol;
    logic [2:0]           cnt;
    logic [2:0]           last;
    logic [2:0]           i01, i23, i45, i03, imin, fsel;
    logic signed [XW-1:0] c01, c23, c03;
    logic signed [XW-1:0] negc;

    assign fe       = !r_v2 || !i_q_full;
    assign o_full   = !fe;
    assign o_q_push = r_v2 && !i_q_full;
    assign o_q_data = r_item;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_c[2*k]   = XW'(i_point[k]) - $signed({3'b000, i_radius}) - XW'(i_box_min[k]);
            n_c[2*k+1] = XW'(i_box_max[k]) - XW'(i_point[k]) - $signed({3'b000, i_radius});
        end
    end

    always_comb begin
        cnt  = '0;
        last = '0;
        for (int i = 0; i < 6; i++) begin
            viol[i] = r_c[i][XW-1];
            cnt     = cnt + {2'b00, viol[i]};
            if (viol[i]) begin
                last = 3'(i);
            end
        end
        // smallest clearance, ties to the later face
        i01  = (r_c[1] <= r_c[0]) ? 3'd1 : 3'd0;
        c01  = (r_c[1] <= r_c[0]) ? r_c[1] : r_c[0];
        i23  = (r_c[3] <= r_c[2]) ? 3'd3 : 3'd2;
        c23  = (r_c[3] <= r_c[2]) ? r_c[3] : r_c[2];
        i45  = (r_c[5] <= r_c[4]) ? 3'd5 : 3'd4;
        i03  = (c23 <= c01) ? i23 : i01;
        c03  = (c23 <= c01) ? c23 : c01;
        imin = (r_c[i45] <= c03) ? i45 : i03;
        fsel = (cnt == 3'd0) ? imin : last;

        n_item.flip   = i_flip;
        n_item.multi  = cnt > 3'd1;
        n_item.in_box = cnt == 3'd0;
        n_item.face   = t_face'(fsel);
        n_item.csel   = r_c[fsel];
        for (int k = 0; k < 3; k++) begin
            n_item.neg[k] = viol[2*k];
            if (viol[2*k]) begin
                negc = -r_c[2*k];
            end else if (viol[2*k+1]) begin
                negc = -r_c[2*k+1];
            end else begin
                negc = '0;
            end
            n_item.ax[k] = negc[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (fe) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_c    <= n_c;
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_sdn_queue.sv =====
// ----------------------------------------------------------------------------
// aabb_sdn_queue
// short register queue between the classifying front and the arithmetic back
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_sdn_queue #(
    parameter int W     = 142,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_full,
    input  logic [W-1:0] i_data,
    output logic         o_empty,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr, rd;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(wr) - CW'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_sdn_back.sv =====
// ----------------------------------------------------------------------------
// aabb_sdn_back
// sum of squares, rounded square root, normal division and output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "aabb_signed_distance_normal_top_macros.svh"

module aabb_sdn_back #(
    parameter int COORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    output logic                         o_q_pop,
    input  logic [aabb_sdn_pkg::item_w(COORD_BITS)-1:0] i_q_data,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [COORD_BITS-1:0] o_distance,
    output logic signed [aabb_sdn_pkg::NORM_W-1:0] o_normal [3],
    output logic                         o_inside_res
);
    import aabb_sdn_pkg::*;

    localparam int AW  = COORD_BITS + 1;
    localparam int XW  = COORD_BITS + 2;
    localparam int H   = (AW + 1) / 2;
    localparam int SQW = 4 * H;
    localparam int SW  = 2 * AW + 2;
    localparam int RB  = AW + 1;
    localparam int RRW = RB + 2;
    localparam int LW  = RB + 1;
    localparam int QW  = DIV_STEPS + 1;
    localparam int DW  = COORD_BITS + 5;

    typedef struct packed {
        logic                  flip;
        logic                  multi;
        logic                  in_box;
        t_face                 face;
        logic signed [XW-1:0]  csel;
        logic [2:0]            neg;
        logic [2:0][AW-1:0]    ax;
    } t_item;

    logic b_en;
    t_item q_item;

    // squares
    logic              r_v1, r_v2;
    t_item             r_it1, r_it2;
    logic [2*H-1:0]    r_hh [3], r_hl [3], r_ll [3];
    logic [2*AW-1:0]   r_sq [3];

    // square root, one result bit per stage
    logic              r_sv   [0:RB];
    t_item             r_sit  [0:RB];
    logic [RB-1:0]     r_root [0:RB];
    logic [RRW-1:0]    r_rem  [0:RB];
    logic [SW-1:0]     r_nsh  [0:RB];

    // rounded length
    logic              r_rv;
    t_item             r_rit;
    logic [LW-1:0]     r_len;

    // division, one quotient bit per stage
    logic              r_dv   [0:DIV_STEPS];
    t_item             r_dit  [0:DIV_STEPS];
    logic [LW-1:0]     r_dlen [0:DIV_STEPS];
    logic [QW-1:0]     r_dq   [0:DIV_STEPS][3];
    logic [LW-1:0]     r_drem [0:DIV_STEPS][3];

    // output
    logic                          r_ov;
    logic signed [COORD_BITS-1:0]  r_odist;
    logic signed [NORM_W-1:0]      r_onrm [3];
    logic                          r_oin;
    logic signed [COORD_BITS-1:0]  n_odist;
    logic signed [NORM_W-1:0]      n_onrm [3];

    assign q_item       = t_item'(i_q_data);
    assign b_en         = !r_ov || pop;
    assign o_q_pop      = b_en && !i_q_empty;
    assign empty        = !r_ov;
    assign o_distance   = r_odist;
    assign o_normal     = r_onrm;
    assign o_inside_res = r_oin;

    // ---------------- squares ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (b_en) begin
            r_v1 <= !i_q_empty;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_it1 <= q_item;
            r_it2 <= r_it1;
            for (int k = 0; k < 3; k++) begin
                r_hh[k] <= H'(q_item.ax[k] >> H) * H'(q_item.ax[k] >> H);
                r_hl[k] <= H'(q_item.ax[k] >> H) * q_item.ax[k][H-1:0];
                r_ll[k] <= q_item.ax[k][H-1:0] * q_item.ax[k][H-1:0];
                r_sq[k] <= (2*AW)'((SQW'(r_hh[k]) << (2*H)) + (SQW'(r_hl[k]) << (H+1))
                                   + SQW'(r_ll[k]));
            end
        end
    end

    // ---------------- square root ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (b_en) begin
            r_sv[0] <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_sit[0]  <= r_it2;
            r_root[0] <= '0;
            r_rem[0]  <= '0;
            r_nsh[0]  <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
        end
    end

    for (genvar s = 1; s <= RB; s++) begin : g_sqrt
        logic [RRW+1:0] cur, trial;

        assign cur   = {r_rem[s-1], r_nsh[s-1][SW-1:SW-2]};
        assign trial = (RRW+2)'({r_root[s-1], 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s] <= 1'b0;
            end else if (b_en) begin
                r_sv[s] <= r_sv[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (b_en) begin
                r_sit[s] <= r_sit[s-1];
                r_nsh[s] <= r_nsh[s-1] << 2;
                if (cur >= trial) begin
                    r_rem[s]  <= RRW'(cur - trial);
                    r_root[s] <= {r_root[s-1][RB-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= RRW'(cur);
                    r_root[s] <= {r_root[s-1][RB-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------- rounding ----------------
    logic [LW-1:0] n_len;

    always_comb begin
        n_len = LW'(r_root[RB]) + LW'(r_rem[RB] > RRW'(r_root[RB]));
        if (n_len == '0) begin
            n_len = LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (b_en) begin
            r_rv <= r_sv[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_rit <= r_sit[RB];
            r_len <= n_len;
        end
    end

    // ---------------- division ----------------
    logic [LW-1:0] d0_rem [3];
    logic          d0_q   [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d0_q[k]   = LW'(r_rit.ax[k]) >= r_len;
            d0_rem[k] = d0_q[k] ? LW'(r_rit.ax[k]) - r_len : LW'(r_rit.ax[k]);
            if (d0_rem[k] >= r_len) begin
                d0_rem[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (b_en) begin
            r_dv[0] <= r_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_dit[0]  <= r_rit;
            r_dlen[0] <= r_len;
            for (int k = 0; k < 3; k++) begin
                r_dq[0][k]   <= QW'(d0_q[k]);
                r_drem[0][k] <= d0_rem[k];
            end
        end
    end

    for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_div
        logic [LW:0] sh [3];

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                sh[k] = {r_drem[s-1][k], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s] <= 1'b0;
            end else if (b_en) begin
                r_dv[s] <= r_dv[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (b_en) begin
                r_dit[s]  <= r_dit[s-1];
                r_dlen[s] <= r_dlen[s-1];
                for (int k = 0; k < 3; k++) begin
                    if (sh[k] >= (LW+1)'(r_dlen[s-1])) begin
                        r_drem[s][k] <= LW'(sh[k] - (LW+1)'(r_dlen[s-1]));
                        r_dq[s][k]   <= {r_dq[s-1][k][QW-2:0], 1'b1};
                    end else begin
                        r_drem[s][k] <= LW'(sh[k]);
                        r_dq[s][k]   <= {r_dq[s-1][k][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // ---------------- result ----------------
    t_item                     fit;
    logic signed [DW-1:0]      dwide;
    logic signed [DW-1:0]      hi_lim, lo_lim;
    logic [QW:0]               qr;
    logic [NORM_W-1:0]         mag;
    logic signed [NORM_W-1:0]  val;

    always_comb begin
        fit    = r_dit[DIV_STEPS];
        hi_lim = $signed({{(DW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
        lo_lim = ~hi_lim;
        qr     = '0;
        mag    = '0;
        val    = '0;
        for (int k = 0; k < 3; k++) begin
            n_onrm[k] = '0;
        end
        if (!fit.multi) begin
            dwide = fit.flip ? -DW'(fit.csel) : DW'(fit.csel);
            val   = fit.face[0] ? -NORM_W'(NORM_ONE) : NORM_W'(NORM_ONE);
            if (fit.flip) begin
                val = -val;
            end
            n_onrm[fit.face[2:1]] = val;
        end else begin
            dwide = fit.flip ? $signed(DW'(r_dlen[DIV_STEPS]))
                             : -$signed(DW'(r_dlen[DIV_STEPS]));
            for (int k = 0; k < 3; k++) begin
                qr  = ((QW+1)'(r_dq[DIV_STEPS][k]) + 1'b1) >> 1;
                mag = (qr > (QW+1)'(NORM_ONE)) ? NORM_W'(NORM_ONE) : NORM_W'(qr);
                val = fit.neg[k] ? $signed(mag) : -$signed(mag);
                n_onrm[k] = fit.flip ? -val : val;
            end
        end
        if (dwide > hi_lim) begin
            n_odist = COORD_BITS'(hi_lim);
        end else if (dwide < lo_lim) begin
            n_odist = COORD_BITS'(lo_lim);
        end else begin
            n_odist = COORD_BITS'(dwide);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (b_en) begin
            r_ov <= r_dv[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_odist <= n_odist;
            r_onrm  <= n_onrm;
            r_oin   <= fit.in_box;
        end
    end

    `AABB_SDN_IMPLIES(a_len_nonzero, i_clk, i_rst_n, r_rv, r_len != '0, "zero length")
    `AABB_SDN_IMPLIES(a_sqrt_rem, i_clk, i_rst_n, r_sv[RB], r_rem[RB] <= (RRW'(r_root[RB]) << 1), "sqrt remainder out of range")
    `AABB_SDN_IMPLIES(a_div_rem, i_clk, i_rst_n, r_dv[DIV_STEPS], r_drem[DIV_STEPS][0] < r_dlen[DIV_STEPS], "division remainder out of range")
    `AABB_SDN_IMPLIES(a_class, i_clk, i_rst_n, r_rv && r_rit.in_box, !r_rit.multi, "inside item marked as multi-face")

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_signed_distance_normal_top.sv =====
// ----------------------------------------------------------------------------
// aabb_signed_distance_normal_top
// signed distance and normal of a sphere centre against an axis-aligned box
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  input     push / full      i_point_x, i_point_y, i_point_z, i_radius
//  result    empty / pop      o_distance, o_normal_x/y/z, o_inside_res
//  config    i_cfg_we         i_cfg_idx, i_cfg_data
//
//  one item per cycle in steady state while pop keeps up with results; the pipeline
//  runs through two front stages, one queue slot, squares, one root bit per stage,
//  rounding, sixteen division stages and the output register
//  a four-entry queue parts front and back; full rises when it and the front fill
//  synchronous active-low reset clears the pipeline and loads the unit box
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_signed_distance_normal_top #(
    parameter int COORD_BITS = aabb_sdn_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = aabb_sdn_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic        [COORD_BITS-2:0] i_radius,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [COORD_BITS-1:0] o_distance,
    output logic signed [aabb_sdn_pkg::NORM_W-1:0] o_normal_x,
    output logic signed [aabb_sdn_pkg::NORM_W-1:0] o_normal_y,
    output logic signed [aabb_sdn_pkg::NORM_W-1:0] o_normal_z,
    output logic                         o_inside_res,
    input  logic                         i_cfg_we,
    input  logic [aabb_sdn_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]        i_cfg_data
);
    import aabb_sdn_pkg::*;

    localparam int IW = item_w(COORD_BITS);
    localparam logic signed [COORD_BITS-1:0] ONE = COORD_BITS'(1) << FRAC_BITS;

    logic signed [COORD_BITS-1:0] r_box_min [3];
    logic signed [COORD_BITS-1:0] r_box_max [3];
    logic                         r_flip;
    logic signed [COORD_BITS-1:0] point [3];
    logic signed [NORM_W-1:0]     nrm [3];

    logic          q_push, q_full, q_empty, q_pop;
    logic [IW-1:0] q_in, q_out;

    assign point[0]   = i_point_x;
    assign point[1]   = i_point_y;
    assign point[2]   = i_point_z;
    assign o_normal_x = nrm[0];
    assign o_normal_y = nrm[1];
    assign o_normal_z = nrm[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_box_min[k] <= -ONE;
                r_box_max[k] <= ONE;
            end
            r_flip <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MIN_X: r_box_min[0] <= i_cfg_data;
                REG_MIN_Y: r_box_min[1] <= i_cfg_data;
                REG_MIN_Z: r_box_min[2] <= i_cfg_data;
                REG_MAX_X: r_box_max[0] <= i_cfg_data;
                REG_MAX_Y: r_box_max[1] <= i_cfg_data;
                REG_MAX_Z: r_box_max[2] <= i_cfg_data;
                REG_FLIP:  r_flip       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    aabb_sdn_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_point   (point),
        .i_radius  (i_radius),
        .i_box_min (r_box_min),
        .i_box_max (r_box_max),
        .i_flip    (r_flip),
        .o_q_push  (q_push),
        .o_q_data  (q_in),
        .i_q_full  (q_full)
    );

    aabb_sdn_queue #(
        .W     (IW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .i_data  (q_in),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    aabb_sdn_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_q_data     (q_out),
        .empty        (empty),
        .pop          (pop),
        .o_distance   (o_distance),
        .o_normal     (nrm),
        .o_inside_res (o_inside_res)
    );

endmodule

`default_nettype wire
